@@ hdl/ptnn_pkg.sv @@
`timescale 1ns / 1ps

package ptnn_pkg;

  localparam int unsigned TABLE_DEPTH = 128;
  localparam int unsigned IDX_W       = 7;
  localparam int unsigned HZ_W        = 24;
  localparam int unsigned LOG_W       = 21;
  localparam int unsigned MANT_W      = 31;
  localparam int unsigned CENTS_W     = 16;
  localparam logic [14:0] CENTS_LIMIT = 15'd24000;
  localparam logic [13:0] CENTS_SCALE = 14'd12000;

  typedef logic [TABLE_DEPTH-1:0][HZ_W-1:0] rom_t;

  // Octave-0 frequencies for C through B with 27 fraction bits.
  localparam logic [11:0][31:0] OCTAVE_BASE = {
    32'd2071496706, 32'd1955232530, 32'd1845493760, 32'd1741914154,
    32'd1644148025, 32'd1551869087, 32'd1464769368, 32'd1382558180,
    32'd1304961152, 32'd1231719311, 32'd1162588218, 32'd1097337155
  };

  function automatic rom_t build_rom();
    rom_t        r;
    int unsigned o;
    longint unsigned v;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      o = i / 12;
      v = (longint'(OCTAVE_BASE[i % 12]) + (64'd1 << (16 - o))) >> (17 - o);
      r[i] = v[HZ_W-1:0];
    end
    return r;
  endfunction

  localparam rom_t NOTE_ROM = build_rom();

  typedef enum logic [1:0] {
    CLS_LOW,
    CLS_HIGH,
    CLS_SEARCH
  } pitch_cls_e;

  typedef struct packed {
    logic [HZ_W-1:0] pitch;
    pitch_cls_e      cls;
  } pitch_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_LOG_START,
    ST_LOG_WAIT,
    ST_SCALE,
    ST_FINISH
  } back_state_e;

endpackage

@@ hdl/ptnn_front.sv @@
`timescale 1ns / 1ps

module ptnn_front import ptnn_pkg::*; #(
  parameter int unsigned NOTE_COUNT = 128
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [HZ_W-1:0]     pitch_hz_i,
  input  logic                pitch_valid_i,
  output logic                pitch_ready_o,
  output pitch_item_t         item_o,
  output logic                item_valid_o,
  input  logic                item_pop_i
);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NOTE_COUNT - 1);

  pitch_item_t mem_q [2];
  logic        wr_ptr_q, rd_ptr_q;
  logic [1:0]  cnt_q;
  logic        push, pop;
  pitch_item_t new_item;

  // Items outside the table range clamp without a search.
  always_comb begin
    new_item.pitch = pitch_hz_i;
    if (pitch_hz_i < NOTE_ROM[0]) begin
      new_item.cls = CLS_LOW;
    end else if (pitch_hz_i > NOTE_ROM[LAST_IDX]) begin
      new_item.cls = CLS_HIGH;
    end else begin
      new_item.cls = CLS_SEARCH;
    end
  end

  assign pitch_ready_o = (cnt_q != 2'd2);
  assign push          = pitch_valid_i && pitch_ready_o;
  assign item_valid_o  = (cnt_q != 2'd0);
  assign pop           = item_pop_i && item_valid_o;
  assign item_o        = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= new_item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

@@ hdl/ptnn_log2.sv @@
`timescale 1ns / 1ps

module ptnn_log2 import ptnn_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [HZ_W-1:0]  x_i,
  output logic             done_o,
  output logic [LOG_W-1:0] log_o
);

  logic [HZ_W-1:0]   x_q, x_d;
  logic [4:0]        e_q, e_d;
  logic [MANT_W-1:0] m_q, m_d, src;
  logic [15:0]       frac_q, frac_d;
  logic [4:0]        cnt_q, cnt_d;
  logic              busy_q, busy_d, done_q, done_d;
  logic [2*MANT_W-1:0] sq;
  logic [31:0]       t;

  assign src = (cnt_q == 5'd5) ? {x_q, 7'b0} : m_q;
  assign sq  = src * src;
  assign t   = sq[61:30];

  // Shifts by 16, 8, 4, 2 and 1 normalize the leading one, then sixteen squares give the fraction.
  always_comb begin
    x_d = x_q; e_d = e_q; m_d = m_q; frac_d = frac_q;
    cnt_d = cnt_q; busy_d = busy_q; done_d = 1'b0;
    if (start_i) begin
      x_d = x_i; e_d = 5'd23; frac_d = '0; cnt_d = '0; busy_d = 1'b1;
    end else if (busy_q) begin
      cnt_d = cnt_q + 5'd1;
      case (cnt_q)
        5'd0: if (x_q[23:8] == '0) begin x_d = {x_q[7:0], 16'b0}; e_d = e_q - 5'd16; end
        5'd1: if (x_q[23:16] == '0) begin x_d = {x_q[15:0], 8'b0}; e_d = e_q - 5'd8; end
        5'd2: if (x_q[23:20] == '0) begin x_d = {x_q[19:0], 4'b0}; e_d = e_q - 5'd4; end
        5'd3: if (x_q[23:22] == '0) begin x_d = {x_q[21:0], 2'b0}; e_d = e_q - 5'd2; end
        5'd4: if (!x_q[23]) begin x_d = {x_q[22:0], 1'b0}; e_d = e_q - 5'd1; end
        default: begin
          frac_d = {frac_q[14:0], t[31]};
          m_d    = t[31] ? t[31:1] : t[30:0];
          if (cnt_q == 5'd20) begin
            busy_d = 1'b0;
            done_d = 1'b1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    e_q    <= e_d;
    m_q    <= m_d;
    frac_q <= frac_d;
    cnt_q  <= cnt_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  assign done_o = done_q;
  assign log_o  = {e_q, frac_q};

endmodule

@@ hdl/ptnn_back.sv @@
`timescale 1ns / 1ps

module ptnn_back import ptnn_pkg::*; #(
  parameter int unsigned NOTE_COUNT = 128
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [HZ_W-1:0]            tolerance_i,
  input  pitch_item_t                item_i,
  input  logic                       item_valid_i,
  output logic                       item_pop_o,
  output logic [IDX_W-1:0]           note_index_o,
  output logic [3:0]                 pitch_class_o,
  output logic [3:0]                 octave_number_o,
  output logic [HZ_W-1:0]            reference_hz_o,
  output logic signed [CENTS_W-1:0]  cents_tenths_o,
  output logic                       in_tune_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i
);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NOTE_COUNT - 1);

  back_state_e state_q, state_d;
  logic [HZ_W-1:0]  p_q;
  logic [IDX_W-1:0] left_q, left_d, right_q, right_d, idx_q, idx_d;
  logic [IDX_W-1:0] mid, mid_m1, mid_p1;
  logic [IDX_W:0]   mid_sum;
  logic [HZ_W-1:0]  t_mid, t_lo, t_hi, ref_hz, diff_mid, diff_ref;
  logic             found;
  logic             log_start, done_p, done_r;
  logic [LOG_W-1:0] log_p, log_r;
  logic signed [LOG_W:0] d;
  logic [LOG_W-1:0] mag;
  logic             neg_q;
  logic [34:0]      prod_q;
  logic [18:0]      rounded;
  logic [14:0]      sat;
  logic [IDX_W+6:0] oct_mul;
  logic [3:0]       oct;
  logic             load_out;

  assign mid_sum = {1'b0, left_q} + {1'b0, right_q};
  assign mid     = mid_sum[IDX_W:1];
  assign mid_m1  = mid - 1'b1;
  assign mid_p1  = mid + 1'b1;
  assign t_mid   = NOTE_ROM[mid];
  assign t_lo    = NOTE_ROM[mid_m1];
  assign t_hi    = NOTE_ROM[mid_p1];
  assign ref_hz  = NOTE_ROM[idx_q];
  assign diff_mid = (p_q >= t_mid) ? p_q - t_mid : t_mid - p_q;
  assign diff_ref = (p_q >= ref_hz) ? p_q - ref_hz : ref_hz - p_q;

  // One probe of the binary search per cycle.
  always_comb begin
    left_d = left_q; right_d = right_q; idx_d = idx_q; found = 1'b0;
    if (left_q >= right_q) begin
      idx_d = LAST_IDX; found = 1'b1;
    end else if (diff_mid < tolerance_i) begin
      idx_d = mid; found = 1'b1;
    end else if (p_q < t_mid) begin
      if (mid != '0 && p_q > t_lo) begin
        idx_d = (p_q - t_lo < t_mid - p_q) ? mid_m1 : mid; found = 1'b1;
      end else begin
        right_d = mid;
      end
    end else begin
      if (mid != LAST_IDX && p_q < t_hi) begin
        idx_d = (p_q - t_mid < t_hi - p_q) ? mid : mid_p1; found = 1'b1;
      end else begin
        left_d = mid_p1;
      end
    end
  end

  ptnn_log2 u_log_p (.clk_i, .rst_ni, .start_i(log_start), .x_i(p_q),
                     .done_o(done_p), .log_o(log_p));
  ptnn_log2 u_log_r (.clk_i, .rst_ni, .start_i(log_start), .x_i(ref_hz),
                     .done_o(done_r), .log_o(log_r));

  assign d   = $signed({1'b0, log_p}) - $signed({1'b0, log_r});
  assign mag = d[LOG_W] ? LOG_W'(-d) : d[LOG_W-1:0];
  assign rounded = 19'((prod_q + 35'd32768) >> 16);
  assign sat = (rounded > 19'(CENTS_LIMIT)) ? CENTS_LIMIT : rounded[14:0];

  // Octave by reciprocal multiply, exact for indexes below 128.
  assign oct_mul = idx_q * 7'd43;
  assign oct     = oct_mul[12:9];

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:      if (item_valid_i) begin
                      state_d = (item_i.cls == CLS_SEARCH) ? ST_SEARCH : ST_LOG_START;
                    end
      ST_SEARCH:    if (found) state_d = ST_LOG_START;
      ST_LOG_START: state_d = ST_LOG_WAIT;
      ST_LOG_WAIT:  if (done_p && done_r) state_d = ST_SCALE;
      ST_SCALE:     state_d = ST_FINISH;
      ST_FINISH:    if (load_out) state_d = ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    item_pop_o = (state_q == ST_IDLE) && item_valid_i;
    log_start  = (state_q == ST_LOG_START);
    load_out   = (state_q == ST_FINISH) && (!out_valid_o || out_ready_i);
  end

  always_ff @(posedge clk_i) begin
    if (item_pop_o) begin
      p_q     <= item_i.pitch;
      left_q  <= '0;
      right_q <= LAST_IDX;
      idx_q   <= (item_i.cls == CLS_HIGH) ? LAST_IDX : '0;
    end else if (state_q == ST_SEARCH) begin
      left_q  <= left_d;
      right_q <= right_d;
      idx_q   <= idx_d;
    end
    if (state_q == ST_LOG_WAIT) begin
      prod_q <= mag * CENTS_SCALE;
      neg_q  <= d[LOG_W];
    end
    if (load_out) begin
      note_index_o    <= idx_q;
      octave_number_o <= oct;
      pitch_class_o   <= 4'(idx_q - 7'(oct) * 7'd12);
      reference_hz_o  <= ref_hz;
      in_tune_o       <= diff_ref < tolerance_i;
      if (p_q == '0) begin
        cents_tenths_o <= -$signed({1'b0, CENTS_LIMIT});
      end else begin
        cents_tenths_o <= neg_q ? -$signed({1'b0, sat}) : $signed({1'b0, sat});
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_o <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_out) begin
        out_valid_o <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

endmodule

@@ hdl/pitch_to_nearest_note_top.sv @@
`timescale 1ns / 1ps
// Path from acceptance to result: the two-item queue, the binary search (skipped for a
// pitch outside the table), a start state, the two log2 units (normalize plus sixteen
// squarings), a wait state that sees them finish, a scaling state and the output load,
// which waits while a held result is not taken. The back end works on one item at a
// time; the queue takes new items while the back end works. Reset (rst_ni low,
// asynchronous) empties the queue, idles the search and sets the tolerance to 1.0 Hz.
module pitch_to_nearest_note_top import ptnn_pkg::*; #(
  parameter int unsigned NOTE_COUNT = 128
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       tolerance_we_i,
  input  logic [HZ_W-1:0]            tolerance_hz_i,
  input  logic [HZ_W-1:0]            pitch_hz_i,
  input  logic                       pitch_valid_i,
  output logic                       pitch_ready_o,
  output logic [IDX_W-1:0]           note_index_o,
  output logic [3:0]                 pitch_class_o,
  output logic [3:0]                 octave_number_o,
  output logic [HZ_W-1:0]            reference_hz_o,
  output logic signed [CENTS_W-1:0]  cents_tenths_o,
  output logic                       in_tune_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i
);

  // The tolerance serves both as the in-tune window and the search early exit.
  logic [HZ_W-1:0] tolerance_q;
  pitch_item_t     item;
  logic            item_valid, item_pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tolerance_q <= 24'd1024;
    end else if (tolerance_we_i) begin
      tolerance_q <= tolerance_hz_i;
    end
  end

  // The front end classifies each item against the table ends and queues it.
  ptnn_front #(.NOTE_COUNT(NOTE_COUNT)) u_front (
    .clk_i, .rst_ni, .pitch_hz_i, .pitch_valid_i, .pitch_ready_o,
    .item_o(item), .item_valid_o(item_valid), .item_pop_i(item_pop)
  );

  // The back end searches, takes both logarithms and holds the result register.
  ptnn_back #(.NOTE_COUNT(NOTE_COUNT)) u_back (
    .clk_i, .rst_ni, .tolerance_i(tolerance_q),
    .item_i(item), .item_valid_i(item_valid), .item_pop_o(item_pop),
    .note_index_o, .pitch_class_o, .octave_number_o, .reference_hz_o,
    .cents_tenths_o, .in_tune_o, .out_valid_o, .out_ready_i
  );

endmodule

@@ hdl/ptnn_checker.sv @@
`timescale 1ns / 1ps

module ptnn_checker import ptnn_pkg::*; (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic [IDX_W-1:0]          note_index_o,
  input logic [3:0]                pitch_class_o,
  input logic [3:0]                octave_number_o,
  input logic signed [CENTS_W-1:0] cents_tenths_o,
  input logic                      out_valid_o,
  input logic                      out_ready_i
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(note_index_o))
    else $error("result item dropped or changed while stalled");

  a_class: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pitch_class_o < 4'd12 && octave_number_o <= 4'd10)
    else $error("pitch class or octave out of range");

  a_split: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> 7'(octave_number_o) * 7'd12 + 7'(pitch_class_o) == note_index_o)
    else $error("octave and pitch class disagree with note index");

  a_cents: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> cents_tenths_o <= 16'sd24000 && cents_tenths_o >= -16'sd24000)
    else $error("cents deviation beyond saturation limit");

endmodule

bind pitch_to_nearest_note_top ptnn_checker u_ptnn_checker (
  .clk_i, .rst_ni, .note_index_o, .pitch_class_o, .octave_number_o,
  .cents_tenths_o, .out_valid_o, .out_ready_i
);
